// File: hw/rtl/tld_pkg.sv
package tld_pkg;

   // Configuration register indexes on the csr_ write channel.
   localparam logic [2:0] RegSoftLimit = 3'd0;
   localparam logic [2:0] RegHardLimit = 3'd1;
   localparam logic [2:0] RegTarget    = 3'd2;
   localparam logic [2:0] RegMinLevel  = 3'd3;
   localparam logic [2:0] RegWarmMix   = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [6:0] SoftLimitReset = 7'd60;
   localparam logic [6:0] HardLimitReset = 7'd80;
   localparam logic [7:0] TargetReset    = 8'd128;
   localparam logic [7:0] MinLevelReset  = 8'd8;
   localparam logic [6:0] WarmMixReset   = 7'd50;

   // Mix percentages above full scale act as full scale.
   localparam logic [6:0] PercentFull = 7'd100;

   // Temperature bands around the soft limit, as 9-bit signed offsets.
   localparam logic signed [8:0] BandWide   = 9'sd6;
   localparam logic signed [8:0] BandMid    = 9'sd4;
   localparam logic signed [8:0] BandNarrow = 9'sd2;

   // Update intervals in seconds.
   localparam logic [6:0] WaitShort  = 7'd1;
   localparam logic [6:0] WaitMid    = 7'd4;
   localparam logic [6:0] WaitLong   = 7'd16;
   localparam logic [6:0] WaitLongest = 7'd64;

   // Division by 100 as a reciprocal multiply: ceil(2^22 / 100) is exact
   // for every product of an 8-bit level and a percentage up to 100.
   localparam logic [15:0] WarmRecip = 16'd41944;
   localparam int          WarmShift = 22;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [6:0] soft_limit;
      logic [6:0] hard_limit;
      logic [7:0] target;
      logic [7:0] min_level;
      logic [6:0] warm_mix;
   } cfg_type;

   // Item passed from the update stage to the duty stage.
   typedef struct packed {
      logic [7:0]  level;
      logic [14:0] warm_product;
      logic        updated;
      logic [6:0]  interval;
   } upd_type;

endpackage

// File: hw/rtl/thermal_led_brightness_derating_core.sv
// Thermal derating of a white LED's brightness.
// The req_ channel carries one temperature sample per one-second tick; each
// transfer yields exactly one transfer on the rsp_ channel with the cold and
// warm PWM duties, an update flag and the wait chosen before the next update.
// The csr_ channel writes the five limit and level registers; csr_ready is
// always high and a write to an unknown index is dropped. Write registers
// only while no tick is in flight.
// A req_ transfer passes the input register, the update register and the
// result register before its rsp_ result appears. One tick is accepted every
// cycle while req_stall is low; the rate is set by the level update, whose
// state is written as each tick leaves the input register.
// Reset clears the level, the countdown and the started flag and loads the
// register defaults; the first tick after reset runs an update.
// When the receiver holds rsp_stall, results stay in place and req_stall
// rises once the pipeline registers have filled.
module thermal_led_brightness_derating_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [7:0]    req_temperature,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_cold_duty,
   output logic [7:0]           rsp_warm_duty,
   output logic                 rsp_updated,
   output logic [6:0]           rsp_interval_seconds,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [7:0]           csr_data
);

   tld_pkg::cfg_type cfg;
   tld_pkg::upd_type upd;
   logic             upd_valid;
   logic             upd_take;

   tld_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tld_update u_update (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_temperature (req_temperature),
      .upd_valid       (upd_valid),
      .upd_take        (upd_take),
      .upd             (upd)
   );

   tld_duty u_duty (
      .clock                (clock),
      .reset                (reset),
      .upd_valid            (upd_valid),
      .upd_take             (upd_take),
      .upd                  (upd),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_cold_duty        (rsp_cold_duty),
      .rsp_warm_duty        (rsp_warm_duty),
      .rsp_updated          (rsp_updated),
      .rsp_interval_seconds (rsp_interval_seconds)
   );

endmodule

// File: hw/rtl/tld_csr.sv
module tld_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [7:0]           csr_data,
   output tld_pkg::cfg_type     cfg
);

   tld_pkg::cfg_type cfg_ff;

   // Writes are always taken.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register file; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.soft_limit <= tld_pkg::SoftLimitReset;
         cfg_ff.hard_limit <= tld_pkg::HardLimitReset;
         cfg_ff.target     <= tld_pkg::TargetReset;
         cfg_ff.min_level  <= tld_pkg::MinLevelReset;
         cfg_ff.warm_mix   <= tld_pkg::WarmMixReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            tld_pkg::RegSoftLimit: cfg_ff.soft_limit <= csr_data[6:0];
            tld_pkg::RegHardLimit: cfg_ff.hard_limit <= csr_data[6:0];
            tld_pkg::RegTarget:    cfg_ff.target     <= csr_data;
            tld_pkg::RegMinLevel:  cfg_ff.min_level  <= csr_data;
            tld_pkg::RegWarmMix:   cfg_ff.warm_mix   <= csr_data[6:0];
            default: ;
         endcase
      end
   end

endmodule

// File: hw/rtl/tld_update.sv
module tld_update (
   input  logic                 clock,
   input  logic                 reset,
   input  tld_pkg::cfg_type     cfg,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [7:0]    req_temperature,
   output logic                 upd_valid,
   input  logic                 upd_take,
   output tld_pkg::upd_type     upd
);

   logic                    s1_valid_ff;
   logic signed [7:0]       s1_temp_ff;
   logic                    s2_valid_ff;
   tld_pkg::upd_type        s2_ff;
   tld_pkg::upd_type        s2_in;

   logic [7:0]              level_ff;
   logic                    started_ff;
   logic [5:0]              seconds_left_ff;
   logic [5:0]              seconds_left_in;

   logic                    s2_free;
   logic                    s1_move;
   logic                    due;
   logic signed [8:0]       temp9;
   logic signed [8:0]       soft9;
   logic signed [8:0]       hard9;
   logic signed [8:0]       delta;
   logic [7:0]              base_level;
   logic [7:0]              step_level;
   logic [6:0]              mix_clamp;

   // Stage handshakes: each register moves when the one after it has room.
   assign s2_free   = !s2_valid_ff || upd_take;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_stall = s1_valid_ff && !s2_free;
   assign upd_valid = s2_valid_ff;
   assign upd       = s2_ff;

   // Sign-extended comparisons of the sample against the limits.
   assign temp9 = {s1_temp_ff[7], s1_temp_ff};
   assign soft9 = {2'b00, cfg.soft_limit};
   assign hard9 = {2'b00, cfg.hard_limit};
   assign delta = temp9 - soft9;
   assign due   = (seconds_left_ff == 6'd0);

   // The first update starts from the target level.
   assign base_level = started_ff ? level_ff : cfg.target;
   assign mix_clamp  = (cfg.warm_mix > tld_pkg::PercentFull) ? tld_pkg::PercentFull
                                                             : cfg.warm_mix;

   // Step rule applied on an update tick.
   always_comb begin
      if (temp9 > hard9) begin
         step_level = cfg.min_level;
      end else if (temp9 <= soft9 && base_level < cfg.target) begin
         step_level = base_level + 8'd1;
      end else if (temp9 > soft9 && base_level > cfg.min_level) begin
         step_level = base_level - 8'd1;
      end else begin
         step_level = base_level;
      end
   end

   // Interval choice, result fields and the next countdown.
   always_comb begin
      s2_in.interval = 7'd0;
      s2_in.updated  = due;
      s2_in.level    = level_ff;
      if (due) begin
         s2_in.level = step_level;
         if (delta > tld_pkg::BandWide || delta < -tld_pkg::BandWide) begin
            s2_in.interval = tld_pkg::WaitShort;
         end else if (delta > tld_pkg::BandMid || delta < -tld_pkg::BandMid) begin
            s2_in.interval = tld_pkg::WaitMid;
         end else if (delta > tld_pkg::BandNarrow || delta < -tld_pkg::BandNarrow) begin
            s2_in.interval = tld_pkg::WaitLong;
         end else begin
            s2_in.interval = tld_pkg::WaitLongest;
         end
      end
      s2_in.warm_product = 15'(s2_in.level) * 15'(mix_clamp);
      seconds_left_in    = due ? (s2_in.interval[5:0] - 6'd1) : (seconds_left_ff - 6'd1);
   end

   // Input register and stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_move;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         s1_temp_ff <= req_temperature;
      end
      if (s1_move) begin
         s2_ff <= s2_in;
      end
   end

   // Derating state advances once per tick as the tick leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff        <= 8'd0;
         started_ff      <= 1'b0;
         seconds_left_ff <= 6'd0;
      end else if (s1_move) begin
         level_ff        <= s2_in.level;
         seconds_left_ff <= seconds_left_in;
         if (due) begin
            started_ff <= 1'b1;
         end
      end
   end

endmodule

// File: hw/rtl/tld_duty.sv
module tld_duty (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 upd_valid,
   output logic                 upd_take,
   input  tld_pkg::upd_type     upd,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_cold_duty,
   output logic [7:0]           rsp_warm_duty,
   output logic                 rsp_updated,
   output logic [6:0]           rsp_interval_seconds
);

   logic         rsp_valid_ff;
   logic [7:0]   cold_ff;
   logic [7:0]   warm_ff;
   logic         updated_ff;
   logic [6:0]   interval_ff;
   logic [30:0]  scaled;
   logic [7:0]   warm_in;

   // The result register takes a new item when empty or being drained.
   assign upd_take = !rsp_valid_ff || !rsp_stall;

   // Warm duty is the registered product divided by 100.
   assign scaled  = 31'(upd.warm_product) * 31'(tld_pkg::WarmRecip);
   assign warm_in = scaled[tld_pkg::WarmShift +: 8];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (upd_take) begin
         rsp_valid_ff <= upd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_take && upd_valid) begin
         cold_ff     <= upd.level;
         warm_ff     <= warm_in;
         updated_ff  <= upd.updated;
         interval_ff <= upd.interval;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_cold_duty        = cold_ff;
   assign rsp_warm_duty        = warm_ff;
   assign rsp_updated          = updated_ff;
   assign rsp_interval_seconds = interval_ff;

endmodule

// File: test/thermal_led_brightness_derating_core_tb.sv
`timescale 1ns / 100ps

module thermal_led_brightness_derating_core_tb;

   localparam int ClockHalf     = 5;
   localparam int ResetCycles   = 11;
   localparam int SettleCycles  = 8;
   localparam int HoldOffCycles = 64;
   localparam int MaxReports    = 10;
   localparam int PhaseTicks    = 150;
   localparam int RandomPhases  = 5;
   localparam longint TimeLimitNs = 64'd5_000_000;

   // First register index past the end of the list; writes there are dropped.
   localparam logic [2:0] RegSpareFirst = 3'd5;

   // One duty report as seen on the rsp_ channel.
   typedef struct packed {
      logic [7:0] cold;
      logic [7:0] warm;
      logic       updated;
      logic [6:0] interval;
   } duty_report_type;

   // Tracks the derating state, predicts each tick's duties and checks them.
   class duty_scoreboard_type;
      logic [6:0]   soft_limit = tld_pkg::SoftLimitReset;
      logic [6:0]   hard_limit = tld_pkg::HardLimitReset;
      logic [7:0]   target     = tld_pkg::TargetReset;
      logic [7:0]   min_lvl    = tld_pkg::MinLevelReset;
      logic [6:0]   warm_mix   = tld_pkg::WarmMixReset;
      logic [7:0]   level      = '0;
      logic         started    = 1'b0;
      logic [5:0]   secs_left  = '0;
      duty_report_type due_q[$];
      int           mismatches    = 0;
      int           ticks_checked = 0;
      int           updates_seen  = 0;
      int           longest_seen  = 0;

      function void write_reg(logic [2:0] idx, logic [7:0] data);
         case (idx)
            tld_pkg::RegSoftLimit: soft_limit = data[6:0];
            tld_pkg::RegHardLimit: hard_limit = data[6:0];
            tld_pkg::RegTarget:    target     = data;
            tld_pkg::RegMinLevel:  min_lvl    = data;
            tld_pkg::RegWarmMix:   warm_mix   = data[6:0];
            default: ;
         endcase
      endfunction

      function void note_tick(logic signed [7:0] temp);
         int              t;
         int              soft_lim;
         int              mix;
         logic [6:0]      next_wait;
         duty_report_type due;
         t = int'(temp);
         soft_lim = int'(soft_limit);
         next_wait = '0;
         due.updated = 1'b0;
         if (secs_left == 0) begin
            // The first update after reset starts from the target level.
            if (!started) begin
               level = target;
               started = 1'b1;
            end
            if (t > int'(hard_limit)) begin
               level = min_lvl;
            end else if (t <= soft_lim && level < target) begin
               level = level + 8'd1;
            end else if (t > soft_lim && level > min_lvl) begin
               level = level - 8'd1;
            end
            // The farther the sample is from the soft limit, the sooner
            // the next update comes.
            if (t > soft_lim + int'(tld_pkg::BandWide) ||
                t < soft_lim - int'(tld_pkg::BandWide)) begin
               next_wait = tld_pkg::WaitShort;
            end else if (t > soft_lim + int'(tld_pkg::BandMid) ||
                         t < soft_lim - int'(tld_pkg::BandMid)) begin
               next_wait = tld_pkg::WaitMid;
            end else if (t > soft_lim + int'(tld_pkg::BandNarrow) ||
                         t < soft_lim - int'(tld_pkg::BandNarrow)) begin
               next_wait = tld_pkg::WaitLong;
            end else begin
               next_wait = tld_pkg::WaitLongest;
            end
            secs_left = 6'(next_wait - 7'd1);
            due.updated = 1'b1;
         end else begin
            secs_left = secs_left - 6'd1;
         end
         // Mix settings above full scale saturate.
         mix = (warm_mix > tld_pkg::PercentFull) ? int'(tld_pkg::PercentFull)
                                                 : int'(warm_mix);
         due.cold = level;
         due.warm = 8'((int'(level) * mix) / int'(tld_pkg::PercentFull));
         due.interval = next_wait;
         due_q.push_back(due);
      endfunction

      function void check_duty(duty_report_type got);
         duty_report_type due;
         ticks_checked++;
         if (due_q.size() == 0) begin
            if (mismatches < MaxReports)
               $display("Unexpected result: cold %0d warm %0d updated %0b wait %0d",
                        got.cold, got.warm, got.updated, got.interval);
            mismatches++;
         end else begin
            due = due_q.pop_front();
            if (due.updated) updates_seen++;
            if (due.interval == tld_pkg::WaitLongest) longest_seen++;
            if (got.cold !== due.cold || got.warm !== due.warm ||
                got.updated !== due.updated || got.interval !== due.interval) begin
               if (mismatches < MaxReports)
                  $display({"Mismatch at tick %0d: expected cold %0d warm %0d ",
                            "updated %0b wait %0d, got cold %0d warm %0d updated %0b ",
                            "wait %0d"}, ticks_checked, due.cold, due.warm,
                           due.updated, due.interval, got.cold, got.warm,
                           got.updated, got.interval);
               mismatches++;
            end
         end
      endfunction

      function int outstanding();
         return due_q.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic signed [7:0] req_temperature = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [7:0]        rsp_cold_duty;
   logic [7:0]        rsp_warm_duty;
   logic              rsp_updated;
   logic [6:0]        rsp_interval_seconds;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = '0;
   logic [7:0]        csr_data = '0;

   duty_scoreboard_type sb = new();
   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;
   bit hold_off_req = 1'b0;
   int settings_used = 1;
   int corner_temps [20] = '{-128, 127, 0, 81, 80, 67, 66, 65, 64, 63,
                             62, 61, 60, 59, 58, 57, 56, 55, 54, 53};

   thermal_led_brightness_derating_core u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_temperature      (req_temperature),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_cold_duty        (rsp_cold_duty),
      .rsp_warm_duty        (rsp_warm_duty),
      .rsp_updated          (rsp_updated),
      .rsp_interval_seconds (rsp_interval_seconds),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #ClockHalf clock = ~clock;

   // Mostly short idle stretches, now and then a long one.
   function automatic int idle_len();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
   endfunction

   // Samples cluster around the soft and hard limits, the rest span the full range.
   function automatic logic signed [7:0] pick_temp();
      int t;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: t = int'(sb.soft_limit) + int'($urandom_range(0, 16)) - 8;
         4, 5:       t = int'(sb.hard_limit) + int'($urandom_range(0, 6)) - 3;
         default:    t = int'($urandom_range(0, 255)) - 128;
      endcase
      if (t > 127) t = 127;
      return 8'(t);
   endfunction

   // Offers one sample, holding it until the transfer happens.
   task automatic send_tick(logic signed [7:0] temp);
      if (!tx_calm && $urandom_range(0, 1) == 1) begin
         req_valid <= 1'b0;
         repeat (idle_len()) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_temperature <= temp;
      do @(posedge clock); while (req_stall);
      sb.note_tick(temp);
   endtask

   task automatic run_random(int count);
      int k;
      for (k = 0; k < count; k++) send_tick(pick_temp());
      req_valid <= 1'b0;
   endtask

   // Waits until every predicted result has arrived and the pipeline is empty.
   task automatic drain();
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   // Rewrites all five registers while idle; the unused top bit of the
   // 7-bit registers carries random data and must be ignored.
   task automatic apply_config(logic [6:0] soft_cfg, logic [6:0] hard, logic [7:0] tgt,
                               logic [7:0] floor_lvl, logic [6:0] mix);
      drain();
      csr_write(tld_pkg::RegSoftLimit, {1'($urandom_range(0, 1)), soft_cfg});
      csr_write(tld_pkg::RegHardLimit, {1'($urandom_range(0, 1)), hard});
      csr_write(tld_pkg::RegTarget, tgt);
      csr_write(tld_pkg::RegMinLevel, floor_lvl);
      csr_write(tld_pkg::RegWarmMix, {1'($urandom_range(0, 1)), mix});
      csr_write(RegSpareFirst + 3'($urandom_range(0, 2)), 8'($urandom));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Receiver pacing: random stalls, calm stretches and one long hold-off.
   initial begin : rsp_pacing
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldOffCycles) @(posedge clock);
         end else if (rx_calm || $urandom_range(0, 9) < 7) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat (idle_len()) @(posedge clock);
         end
      end
   end

   // Every result transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_duty('{cold: rsp_cold_duty, warm: rsp_warm_duty,
                         updated: rsp_updated, interval: rsp_interval_seconds});
   end

   initial begin : stimulus
      int k;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Corner samples under the reset settings, then random ones.
      for (k = 0; k < 20; k++) send_tick(8'(corner_temps[k]));
      req_valid <= 1'b0;
      run_random(PhaseTicks);

      // Everything at zero.
      apply_config(7'd0, 7'd0, 8'd0, 8'd0, 7'd0);
      run_random(PhaseTicks);

      // Everything at its top, mix past full scale; no idling on either side.
      tx_calm = 1'b1;
      rx_calm = 1'b1;
      apply_config(7'd127, 7'd127, 8'd255, 8'd255, 7'd127);
      run_random(PhaseTicks);
      tx_calm = 1'b0;
      rx_calm = 1'b0;

      // Hard limit below the soft limit, mix at exactly full scale.
      apply_config(7'd90, 7'd30, 8'd200, 8'd10, tld_pkg::PercentFull);
      run_random(PhaseTicks);

      // Target below the minimum level.
      apply_config(7'd40, 7'd70, 8'd5, 8'd200, 7'd33);
      run_random(PhaseTicks);

      // Random settings; the first phase also backs up the pipeline with a
      // long receiver hold-off while samples keep coming.
      for (k = 0; k < RandomPhases; k++) begin
         apply_config(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      7'($urandom_range(0, 127)));
         tx_calm = (k == 0);
         rx_calm = (k == 3);
         hold_off_req = (k == 0);
         run_random(PhaseTicks);
      end

      drain();
      $display("Checked %0d ticks under %0d register settings: %0d updates,",
               sb.ticks_checked, settings_used, sb.updates_seen);
      $display("%0d of them chose the longest wait.", sb.longest_seen);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Ends a hung run.
   initial begin : watchdog
      #(TimeLimitNs);
      $display("status: fail");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/tld_pkg.sv
hw/rtl/tld_csr.sv
hw/rtl/tld_update.sv
hw/rtl/tld_duty.sv
hw/rtl/thermal_led_brightness_derating_core.sv
test/thermal_led_brightness_derating_core_tb.sv
